@@ src/peq_pkg.sv @@
// Shared types and constants for the paced event queue.
// Used by the controller, the datapath, the top level and the checker.
package peq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int USER_COUNT_DEF  = 4;

    localparam int EVENT_W    = 64;
    localparam int MARK_W     = 64;
    localparam int USER_IN_W  = 8;
    localparam int SAVE_USER_W = 2;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_NOTE = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_SAVE   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SINK     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'd1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;

    typedef struct packed {
        logic       latch;
        logic       push;
        logic       note;
        logic       pop;
        logic       scan_clr;
        logic       scan_inc;
        logic       use_scan;
        logic       clr_dirty;
        logic       out_load;
        logic [1:0] out_kind;
        logic       out_last;
        logic       out_pend;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       sink;
        logic       empty;
        logic       hold;
        logic       dirty_sel;
        logic       scan_last;
        logic       pending;
    } t_dp_sts;

endpackage

@@ src/paced_event_queue_with_watermarks.sv @@
// Each input beat is latched in the idle state and decoded: a push, a note or a sinkless tick
// ends there with its reply or status (a note gives no output beat). A waiting tick then goes to
// the status state; an emitting tick goes through the emit state (event beat) and then status; an
// idle-queue tick scans every user slot, with a save beat for each dirty one, then goes to status.
// The block takes one input beat at a time and stalls its input until it is back in idle.
// Reset is synchronous and active low; it empties the queue and clears all marks and dirty bits.
module paced_event_queue_with_watermarks #(
    parameter int QUEUE_DEPTH = peq_pkg::QUEUE_DEPTH_DEF,
    parameter int USER_COUNT  = peq_pkg::USER_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [peq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [peq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic [peq_pkg::EVENT_W-1:0]       i_event_word,
    input  logic [peq_pkg::USER_IN_W-1:0]     i_user_index,
    input  logic signed [peq_pkg::MARK_W-1:0] i_mark_value,
    input  logic [peq_pkg::TIME_W-1:0]        i_now_time,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_kind,
    output logic                              o_accepted,
    output logic [peq_pkg::EVENT_W-1:0]       o_out_event,
    output logic [peq_pkg::SAVE_USER_W-1:0]   o_save_user,
    output logic signed [peq_pkg::MARK_W-1:0] o_save_mark,
    output logic                              o_more_pending,
    output logic                              o_last
);

    peq_pkg::t_dp_cmd cmd;
    peq_pkg::t_dp_sts sts;

    peq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    peq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .USER_COUNT  (USER_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_event_word   (i_event_word),
        .i_user_index   (i_user_index),
        .i_mark_value   (i_mark_value),
        .i_now_time     (i_now_time),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_kind         (o_kind),
        .o_accepted     (o_accepted),
        .o_out_event    (o_out_event),
        .o_save_user    (o_save_user),
        .o_save_mark    (o_save_mark),
        .o_more_pending (o_more_pending),
        .o_last         (o_last)
    );

endmodule

@@ src/peq_ctrl.sv @@
// Sequencing state machine for the paced event queue.
// Depends on peq_pkg for the command and status structs and the codes.
module peq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    input  peq_pkg::t_dp_sts i_sts,
    output peq_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_EMIT   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_STATUS = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;
    peq_pkg::t_dp_cmd cmd;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_sts.func)
                    peq_pkg::FUNC_PUSH: begin
                        if (out_free) begin
                            cmd.push     = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_kind = peq_pkg::KIND_PUSH;
                            cmd.out_last = 1'b1;
                            n_state      = ST_IDLE;
                        end
                    end
                    peq_pkg::FUNC_NOTE: begin
                        cmd.note = 1'b1;
                        n_state  = ST_IDLE;
                    end
                    peq_pkg::FUNC_TICK: begin
                        if (!i_sts.sink) begin
                            if (out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = peq_pkg::KIND_STATUS;
                                cmd.out_last = 1'b1;
                                n_state      = ST_IDLE;
                            end
                        end else if (i_sts.empty) begin
                            cmd.scan_clr = 1'b1;
                            n_state      = ST_SCAN;
                        end else if (i_sts.hold) begin
                            n_state = ST_STATUS;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.pop      = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_kind = peq_pkg::KIND_EVENT;
                    n_state      = ST_STATUS;
                end
            end
            ST_SCAN: begin
                cmd.use_scan = 1'b1;
                if (i_sts.dirty_sel) begin
                    if (out_free) begin
                        cmd.clr_dirty = 1'b1;
                        cmd.out_load  = 1'b1;
                        cmd.out_kind  = peq_pkg::KIND_SAVE;
                        if (i_sts.scan_last) begin
                            n_state = ST_STATUS;
                        end else begin
                            cmd.scan_inc = 1'b1;
                        end
                    end
                end else if (i_sts.scan_last) begin
                    n_state = ST_STATUS;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = peq_pkg::KIND_STATUS;
                    cmd.out_last = 1'b1;
                    cmd.out_pend = i_sts.pending;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ src/peq_dp.sv @@
// Datapath of the paced event queue: event memory, pointers, marks, config and result register.
// Depends on peq_pkg; driven by commands from peq_ctrl.
module peq_dp #(
    parameter int QUEUE_DEPTH = peq_pkg::QUEUE_DEPTH_DEF,
    parameter int USER_COUNT  = peq_pkg::USER_COUNT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [peq_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [peq_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic [1:0]                             i_func,
    input  logic [peq_pkg::EVENT_W-1:0]            i_event_word,
    input  logic [peq_pkg::USER_IN_W-1:0]          i_user_index,
    input  logic signed [peq_pkg::MARK_W-1:0]      i_mark_value,
    input  logic [peq_pkg::TIME_W-1:0]             i_now_time,
    input  peq_pkg::t_dp_cmd                       i_cmd,
    output peq_pkg::t_dp_sts                       o_sts,
    output logic [1:0]                             o_kind,
    output logic                                   o_accepted,
    output logic [peq_pkg::EVENT_W-1:0]            o_out_event,
    output logic [peq_pkg::SAVE_USER_W-1:0]        o_save_user,
    output logic signed [peq_pkg::MARK_W-1:0]      o_save_mark,
    output logic                                   o_more_pending,
    output logic                                   o_last
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int USER_W = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;

    logic [peq_pkg::EVENT_W-1:0]       r_mem [QUEUE_DEPTH];
    logic [peq_pkg::EVENT_W-1:0]       r_rd_data;
    logic [PTR_W-1:0]                  r_rd_ptr;
    logic [PTR_W-1:0]                  r_wr_ptr;
    logic [CNT_W-1:0]                  r_fill;
    logic signed [peq_pkg::MARK_W-1:0] r_marks [USER_COUNT];
    logic [USER_COUNT-1:0]             r_dirty;
    logic [peq_pkg::TIME_W-1:0]        r_last_emit;
    logic                              r_sink;
    logic [peq_pkg::INTERVAL_W-1:0]    r_interval;
    logic [USER_W-1:0]                 r_scan;

    logic [1:0]                        r_func;
    logic [peq_pkg::EVENT_W-1:0]       r_event;
    logic [peq_pkg::USER_IN_W-1:0]     r_user;
    logic signed [peq_pkg::MARK_W-1:0] r_mark;
    logic [peq_pkg::TIME_W-1:0]        r_now;

    logic [USER_W-1:0]                 addr;
    logic                              full;
    logic                              user_ok;
    logic                              mark_up;
    logic [peq_pkg::TIME_W-1:0]        elapsed;

    assign addr    = i_cmd.use_scan ? r_scan : r_user[USER_W-1:0];
    assign full    = (r_fill == CNT_W'(QUEUE_DEPTH));
    assign user_ok = (r_user < peq_pkg::USER_IN_W'(USER_COUNT));
    assign mark_up = user_ok && (r_mark > r_marks[addr]);
    assign elapsed = r_now - r_last_emit;

    always_comb begin
        o_sts.func      = r_func;
        o_sts.sink      = r_sink;
        o_sts.empty     = (r_fill == '0);
        o_sts.hold      = (r_last_emit != '0)
                          && (elapsed < peq_pkg::TIME_W'(r_interval));
        o_sts.dirty_sel = r_dirty[addr];
        o_sts.scan_last = (r_scan == USER_W'(USER_COUNT - 1));
        o_sts.pending   = (r_fill != '0) || (|r_dirty);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_mem[r_wr_ptr] <= r_event;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= i_func;
            r_event <= i_event_word;
            r_user  <= i_user_index;
            r_mark  <= i_mark_value;
            r_now   <= i_now_time;
        end
        if (i_cmd.out_load) begin
            o_kind         <= i_cmd.out_kind;
            o_last         <= i_cmd.out_last;
            o_accepted     <= (i_cmd.out_kind == peq_pkg::KIND_PUSH) && !full;
            o_out_event    <= (i_cmd.out_kind == peq_pkg::KIND_EVENT) ? r_rd_data : '0;
            o_save_user    <= (i_cmd.out_kind == peq_pkg::KIND_SAVE)
                              ? peq_pkg::SAVE_USER_W'(r_scan) : '0;
            o_save_mark    <= (i_cmd.out_kind == peq_pkg::KIND_SAVE) ? r_marks[addr] : '0;
            o_more_pending <= (i_cmd.out_kind == peq_pkg::KIND_STATUS) && i_cmd.out_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_dirty     <= '0;
            r_last_emit <= '0;
            r_sink      <= 1'b1;
            r_interval  <= peq_pkg::INTERVAL_RESET;
            r_scan      <= '0;
            for (int u = 0; u < USER_COUNT; u++) begin
                r_marks[u] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    peq_pkg::CFG_SINK:     r_sink     <= i_cfg_data[0];
                    peq_pkg::CFG_INTERVAL: r_interval <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.push && !full) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                r_fill   <= r_fill + 1'b1;
            end
            if (i_cmd.pop) begin
                r_rd_ptr    <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
                r_fill      <= r_fill - 1'b1;
                r_last_emit <= r_now;
            end
            if (i_cmd.note && mark_up) begin
                r_marks[addr] <= r_mark;
                r_dirty[addr] <= 1'b1;
            end
            if (i_cmd.clr_dirty) begin
                r_dirty[addr] <= 1'b0;
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

endmodule

@@ src/peq_chk.sv @@
// Port-level checker for the paced event queue, attached to the top level by bind.
// Depends on peq_pkg for the result kind codes.
module peq_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [1:0]                        o_kind,
    input logic                              o_accepted,
    input logic [peq_pkg::EVENT_W-1:0]       o_out_event,
    input logic                              o_more_pending,
    input logic                              o_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the output beat or the input stall");

    a_mid_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == peq_pkg::KIND_EVENT || o_kind == peq_pkg::KIND_SAVE)
        |-> !o_last)
        else $error("an event or save beat was marked last");

    a_push_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == peq_pkg::KIND_PUSH
        |-> o_last && o_out_event == '0 && !o_more_pending)
        else $error("push reply beat has wrong framing or stray fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall
        |=> o_out_valid && $stable(o_kind) && $stable(o_accepted) && $stable(o_last))
        else $error("stalled output beat changed");

endmodule

bind paced_event_queue_with_watermarks peq_chk u_peq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kind         (o_kind),
    .o_accepted     (o_accepted),
    .o_out_event    (o_out_event),
    .o_more_pending (o_more_pending),
    .o_last         (o_last)
);

@@ verif/tb_paced_event_queue_with_watermarks.sv @@
// Self-checking testbench for paced_event_queue_with_watermarks: a directed table, then random phases.
// It models the queue, marks and pacing; each output beat is checked against it or a typed row.
// Depends on peq_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_paced_event_queue_with_watermarks;

    localparam int DEPTH = peq_pkg::QUEUE_DEPTH_DEF;
    localparam int USERS = peq_pkg::USER_COUNT_DEF;
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [1:0]                    func;
        logic [peq_pkg::EVENT_W-1:0]   word;
        logic [peq_pkg::USER_IN_W-1:0] user;
        logic [peq_pkg::MARK_W-1:0]    mark;
        logic [peq_pkg::TIME_W-1:0]    now;
    } t_beat;

    typedef struct packed {
        logic [1:0]                      kind;
        logic                            accepted;
        logic [peq_pkg::EVENT_W-1:0]     out_event;
        logic [peq_pkg::SAVE_USER_W-1:0] save_user;
        logic [peq_pkg::MARK_W-1:0]      save_mark;
        logic                            more_pending;
        logic                            last;
    } t_result;

    typedef struct packed {
        t_beat      beat;
        logic       typed;
        logic [1:0] t_kind;
        logic       t_flag;
    } t_row;

    localparam int N_DIRECTED = 23;
    localparam t_row DIRECTED [0:N_DIRECTED-1] = '{
        '{'{peq_pkg::FUNC_TICK, 64'h0, 8'd0, 64'h0, 32'd0}, 1'b1, peq_pkg::KIND_STATUS, 1'b0},
        '{'{peq_pkg::FUNC_PUSH, 64'h0, 8'd0, 64'h0, 32'd0}, 1'b1, peq_pkg::KIND_PUSH, 1'b1},
        '{'{peq_pkg::FUNC_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 64'h0, 32'd0}, 1'b1,
            peq_pkg::KIND_PUSH, 1'b1},
        '{'{peq_pkg::FUNC_PUSH, 64'h0123_4567_89AB_CDEF, 8'd0, 64'h0, 32'd0}, 1'b0,
            peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_PUSH, 64'hFEDC_BA98_7654_3210, 8'd0, 64'h0, 32'd0}, 1'b0,
            peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_TICK, 64'h0, 8'd0, 64'h0, 32'd0}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_TICK, 64'h0, 8'd0, 64'h0, 32'd3}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_TICK, 64'h0, 8'd0, 64'h0, 32'd50}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_TICK, 64'h0, 8'd0, 64'h0, 32'd103}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_TICK, 64'h0, 8'd0, 64'h0, 32'd102}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_NOTE, 64'h0, 8'd0, 64'h0, 32'd0}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_NOTE, 64'h0, 8'd1, 64'h8000_0000_0000_0000, 32'd0}, 1'b0,
            peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_NOTE, 64'h0, 8'd1, 64'h1, 32'd0}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_NOTE, 64'h0, 8'd3, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0}, 1'b0,
            peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_NOTE, 64'h0, 8'd4, 64'h5, 32'd0}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_NOTE, 64'h0, 8'd255, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0}, 1'b0,
            peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_NOTE, 64'h0, 8'd1, 64'h1, 32'd0}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF,
            32'hFFFF_FFFF}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_TICK, 64'h0, 8'd0, 64'h0, 32'hFFFF_FFFF}, 1'b0,
            peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_TICK, 64'h0, 8'd0, 64'h0, 32'd0}, 1'b1, peq_pkg::KIND_STATUS, 1'b0},
        '{'{peq_pkg::FUNC_NOTE, 64'h0, 8'd2, 64'd42, 32'd0}, 1'b0, peq_pkg::KIND_PUSH, 1'b0},
        '{'{peq_pkg::FUNC_PUSH, 64'h8000_0000_0000_0001, 8'd0, 64'h0, 32'd0}, 1'b1,
            peq_pkg::KIND_PUSH, 1'b1},
        '{'{peq_pkg::FUNC_TICK, 64'h0, 8'd0, 64'h0, 32'hFFFF_FFFF}, 1'b0,
            peq_pkg::KIND_PUSH, 1'b0}
    };

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [peq_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [peq_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [1:0]                          i_func = '0;
    logic [peq_pkg::EVENT_W-1:0]         i_event_word = '0;
    logic [peq_pkg::USER_IN_W-1:0]       i_user_index = '0;
    logic signed [peq_pkg::MARK_W-1:0]   i_mark_value = '0;
    logic [peq_pkg::TIME_W-1:0]          i_now_time = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [1:0]                          o_kind;
    logic                                o_accepted;
    logic [peq_pkg::EVENT_W-1:0]         o_out_event;
    logic [peq_pkg::SAVE_USER_W-1:0]     o_save_user;
    logic signed [peq_pkg::MARK_W-1:0]   o_save_mark;
    logic                                o_more_pending;
    logic                                o_last;

    paced_event_queue_with_watermarks uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_event_word   (i_event_word),
        .i_user_index   (i_user_index),
        .i_mark_value   (i_mark_value),
        .i_now_time     (i_now_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_accepted     (o_accepted),
        .o_out_event    (o_out_event),
        .o_save_user    (o_save_user),
        .o_save_mark    (o_save_mark),
        .o_more_pending (o_more_pending),
        .o_last         (o_last)
    );

    // Model of the block's state and registers.
    logic [peq_pkg::EVENT_W-1:0]       q_mem [DEPTH];
    logic [PTR_W-1:0]                  q_rd = '0;
    logic [PTR_W-1:0]                  q_wr = '0;
    int                                q_fill = 0;
    logic signed [peq_pkg::MARK_W-1:0] mk_marks [USERS];
    logic [USERS-1:0]                  mk_dirty = '0;
    logic [peq_pkg::TIME_W-1:0]        last_emit = '0;
    logic                              sink_on = 1'b1;
    logic [peq_pkg::INTERVAL_W-1:0]    interval_reg = peq_pkg::INTERVAL_RESET;

    t_result    awaited_results [$];
    int         fails = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    logic       hold_on = 1'b0;
    event       hold_go;
    logic [peq_pkg::TIME_W-1:0] clock_now = '0;
    t_result    got;
    t_result    want;

    initial begin
        for (int u = 0; u < USERS; u++) begin
            mk_marks[u] = '0;
        end
    end

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("paced_event_queue_with_watermarks verification failed");
        $finish;
    end

    function automatic string show(input t_result r);
        return $sformatf("kind=%0d acc=%0d ev=%h user=%0d mark=%h pend=%0d last=%0d",
                         r.kind, r.accepted, r.out_event, r.save_user, r.save_mark,
                         r.more_pending, r.last);
    endfunction

    function automatic void add_result(input t_result r);
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    // Applies one accepted input beat to the model and queues the output beats it causes.
    function automatic int queue_reaction(input t_beat b);
        t_result r;
        t_result s;
        logic [peq_pkg::TIME_W-1:0] since;
        int n;
        r = '0;
        n = 0;
        case (b.func)
            peq_pkg::FUNC_PUSH: begin
                r.kind = peq_pkg::KIND_PUSH;
                if (q_fill < DEPTH) begin
                    q_mem[q_wr] = b.word;
                    q_wr = q_wr + 1'b1;
                    q_fill++;
                    r.accepted = 1'b1;
                end
                r.last = 1'b1;
                add_result(r);
                n = 1;
            end
            peq_pkg::FUNC_NOTE: begin
                if (b.user < USERS) begin
                    if ($signed(b.mark) > mk_marks[b.user]) begin
                        mk_marks[b.user] = $signed(b.mark);
                        mk_dirty[b.user] = 1'b1;
                    end
                end
            end
            peq_pkg::FUNC_TICK: begin
                r.kind = peq_pkg::KIND_STATUS;
                r.last = 1'b1;
                since = b.now - last_emit;
                if (sink_on && q_fill == 0) begin
                    for (int u = 0; u < USERS; u++) begin
                        if (mk_dirty[u]) begin
                            mk_dirty[u] = 1'b0;
                            s = '0;
                            s.kind = peq_pkg::KIND_SAVE;
                            s.save_user = peq_pkg::SAVE_USER_W'(u);
                            s.save_mark = mk_marks[u];
                            add_result(s);
                            n++;
                        end
                    end
                end else if (sink_on && last_emit != 0
                             && since < peq_pkg::TIME_W'(interval_reg)) begin
                    r.more_pending = 1'b1;
                end else if (sink_on) begin
                    s = '0;
                    s.kind = peq_pkg::KIND_EVENT;
                    s.out_event = q_mem[q_rd];
                    last_emit = b.now;
                    q_rd = q_rd + 1'b1;
                    q_fill--;
                    add_result(s);
                    n++;
                    r.more_pending = (q_fill != 0) || (|mk_dirty);
                end
                add_result(r);
                n++;
            end
            default: ;
        endcase
        return n;
    endfunction

    function automatic t_beat pick_beat();
        t_beat b;
        int r;
        b.func = peq_pkg::FUNC_PUSH;
        b.word = {$urandom, $urandom};
        b.user = peq_pkg::USER_IN_W'($urandom_range(0, 255));
        b.mark = {$urandom, $urandom};
        b.now = $urandom;
        r = $urandom_range(0, 99);
        if (r >= 35 && r < 60) begin
            b.func = peq_pkg::FUNC_NOTE;
            if ($urandom_range(0, 9) < 8) begin
                b.user = peq_pkg::USER_IN_W'($urandom_range(0, USERS - 1));
                if ($urandom_range(0, 3) != 0) begin
                    b.mark = mk_marks[b.user] + $urandom_range(1, 5000);
                end
            end
        end else if (r >= 60 && r < 95) begin
            b.func = peq_pkg::FUNC_TICK;
            clock_now = clock_now + $urandom_range(0, 160);
            if ($urandom_range(0, 9) != 0) begin
                b.now = clock_now;
            end
        end else if (r >= 95) begin
            b.func = FUNC_UNUSED;
        end
        return b;
    endfunction

    // Offers one beat after a random gap and returns at the edge where it is taken.
    task automatic send_beat(input t_beat b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func       <= b.func;
        i_event_word <= b.word;
        i_user_index <= b.user;
        i_mark_value <= b.mark;
        i_now_time   <= b.now;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic feed(input t_beat b);
        send_beat(b);
        void'(queue_reaction(b));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic sink, input logic [peq_pkg::INTERVAL_W-1:0] interval);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= peq_pkg::CFG_SINK;
        i_cfg_data  <= peq_pkg::CFG_DATA_W'(sink);
        @(posedge i_clk);
        sink_on = sink;
        i_cfg_index <= peq_pkg::CFG_INTERVAL;
        i_cfg_data  <= interval;
        @(posedge i_clk);
        interval_reg = interval;
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic sink, input logic [peq_pkg::INTERVAL_W-1:0] interval,
                             input int idle, input int stall, input int count);
        settle();
        set_mode(sink, interval);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count) feed(pick_beat());
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
    end

    initial begin
        forever begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (300) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_kind, o_accepted, o_out_event, o_save_user, o_save_mark,
                    o_more_pending, o_last};
            if (awaited_results.size() == 0) begin
                fails++;
                if (fails <= 10) begin
                    $display("unexpected output beat: %s", show(got));
                end
            end else begin
                want = awaited_results.pop_front();
                if (got != want) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("output beat mismatch: expected %s", show(want));
                        $display("                      actual   %s", show(got));
                    end
                end
            end
        end
    end

    initial begin
        t_beat b;
        t_result typed_r;
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_beat(DIRECTED[i].beat);
            n = queue_reaction(DIRECTED[i].beat);
            if (DIRECTED[i].typed) begin
                repeat (n) void'(awaited_results.pop_back());
                typed_r = '0;
                typed_r.kind = DIRECTED[i].t_kind;
                typed_r.last = 1'b1;
                if (DIRECTED[i].t_kind == peq_pkg::KIND_PUSH) begin
                    typed_r.accepted = DIRECTED[i].t_flag;
                end else begin
                    typed_r.more_pending = DIRECTED[i].t_flag;
                end
                add_result(typed_r);
            end
        end

        run_phase(1'b1, 16'd0, 0, 0, 16);
        run_phase(1'b1, 16'hFFFF, 72, 0, 16);
        clock_now = 32'hFFFF_FF00;
        run_phase(1'b1, 16'd37, 0, 72, 16);
        run_phase(1'b0, 16'd100, 28, 28, 12);

        // Empty the queue, push past full against a long receiver hold-off, then tick it again.
        settle();
        set_mode(1'b1, 16'd0);
        idle_pct = 0;
        stall_pct = 28;
        while (q_fill != 0) begin
            b = pick_beat();
            b.func = peq_pkg::FUNC_TICK;
            feed(b);
        end
        -> hold_go;
        repeat (DEPTH + 4) begin
            b = pick_beat();
            b.func = peq_pkg::FUNC_PUSH;
            feed(b);
        end
        repeat (8) begin
            b = pick_beat();
            b.func = peq_pkg::FUNC_TICK;
            clock_now = clock_now + 1'b1;
            b.now = clock_now;
            feed(b);
        end

        run_phase(1'b1, 16'd20, 28, 28, 24);

        settle();
        if (fails == 0) begin
            $display("paced_event_queue_with_watermarks verification clean");
        end else begin
            $display("paced_event_queue_with_watermarks verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/peq_pkg.sv
src/peq_ctrl.sv
src/peq_dp.sv
src/paced_event_queue_with_watermarks.sv
src/peq_chk.sv
verif/tb_paced_event_queue_with_watermarks.sv
